FILE: design/assert_macros.svh
// Assertion helpers shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker assertion failed");

`endif

FILE: design/sft_pkg.sv
package sft_pkg;

   localparam int SFT_LINES_W = 16;
   localparam int SFT_USED_W  = 17;

   localparam logic [2:0] MODE_LOOKUP     = 3'd0;
   localparam logic [2:0] MODE_LOOKUP_ANY = 3'd1;
   localparam logic [2:0] MODE_RESERVE    = 3'd2;
   localparam logic [2:0] MODE_FILL       = 3'd3;
   localparam logic [2:0] MODE_COUNT_UP   = 3'd4;
   localparam logic [2:0] MODE_FLUSH      = 3'd5;
   localparam logic [2:0] MODE_FLUSH_W    = 3'd6;
   localparam logic [2:0] MODE_SPACE      = 3'd7;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_ROOM    = 3'd1;
   localparam logic [2:0] ST_PRESENT    = 3'd2;
   localparam logic [2:0] ST_MISMATCH   = 3'd3;
   localparam logic [2:0] ST_NOT_ALLOC  = 3'd4;
   localparam logic [2:0] ST_BAD_FILL   = 3'd5;
   localparam logic [2:0] ST_TABLE_FULL = 3'd6;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_ACC_MODE = 1'b1;

   localparam logic [SFT_USED_W-1:0] CAPACITY_RESET = 17'd4096;

   typedef struct packed {
      logic [2:0]  mode;
      logic        buffer_sel;
      logic [31:0] tile_address;
      logic [15:0] alloc_lines;
      logic [15:0] request_count;
      logic        holds_input;
   } sft_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        present;
      logic        ready_res;
      logic        reserved_new;
      logic        room_for_size;
      logic        not_full;
      logic [16:0] used_lines;
   } sft_rsp_type;

   typedef struct packed {
      logic load_req;
      logic load_match;
      logic rd_sweep;
      logic exec;
      logic load_rsp;
   } sft_cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       sweep_last;
      logic       rsp_free;
   } sft_sts_type;

endpackage

FILE: design/sft_ram.sv
module sft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sft_ctrl.sv
`include "assert_macros.svh"

module sft_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sft_pkg::sft_sts_type sts,
   output sft_pkg::sft_cmd_type cmd
);
   import sft_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_EXEC   = 3'd5;
   localparam logic [2:0] S_POST   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.load_match = 1'b1;
            state_in = (sts.mode == MODE_FLUSH_W) ? S_SWEEP : S_READ;
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_SWEEP: begin
            cmd.rd_sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_POST;
         end
         S_POST: begin
            cmd.load_rsp = sts.rsp_free;
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `SFT_ASSERT_NEXT(a_exec_after_read, clock, reset, cmd.exec, state_ff == S_POST)
   `SFT_ASSERT_IMPLY(a_exec_source, clock, reset, cmd.exec,
      $past(state_ff) == S_READ || $past(state_ff) == S_DRAIN)
   `SFT_ASSERT_NEXT(a_rsp_to_idle, clock, reset, cmd.load_rsp, req_ready)

endmodule

FILE: design/sft_dp.sv
`include "assert_macros.svh"

module sft_dp #(
   parameter int TABLE_ENTRIES = 64,
   parameter int ADDRESS_BITS  = 32,
   parameter int COUNT_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sft_pkg::sft_cmd_type cmd,
   output sft_pkg::sft_sts_type sts,
   input  sft_pkg::sft_req_type req_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [16:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sft_pkg::sft_rsp_type rsp_data
);
   import sft_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int FW = SFT_LINES_W + IW;
   localparam int SW = (FW > SFT_USED_W) ? FW : SFT_USED_W;

   function automatic logic [IW-1:0] encode(input logic [TABLE_ENTRIES-1:0] vec);
      logic [IW-1:0] idx;
      idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (vec[i]) begin
            idx = idx | IW'(i);
         end
      end
      return idx;
   endfunction

   // Tag side of the table, compared in parallel.
   logic [TABLE_ENTRIES-1:0] used_ff;
   logic [TABLE_ENTRIES-1:0] sbuf_ff;
   logic [TABLE_ENTRIES-1:0] sin_ff;
   logic [ADDRESS_BITS-1:0]  saddr_ff [TABLE_ENTRIES];

   sft_req_type              req_ff;
   logic                     hit_ff;
   logic [IW-1:0]            hit_idx_ff;
   logic                     free_ok_ff;
   logic [IW-1:0]            free_idx_ff;
   logic [TABLE_ENTRIES-1:0] wmask_ff;
   logic [IW-1:0]            cnt_ff;
   logic                     acc_vld_ff;
   logic [IW-1:0]            acc_idx_ff;
   logic [FW-1:0]            freed_ff;
   logic [SFT_USED_W-1:0]    liu_ff [2];
   logic [SFT_USED_W-1:0]    cap_ff;
   logic                     acc_mode_ff;
   logic [2:0]               res_status_ff;
   logic                     res_present_ff;
   logic                     res_ready_ff;
   logic                     res_fresh_ff;
   sft_rsp_type              rsp_ff;
   logic                     rsp_valid_ff;

   logic [ADDRESS_BITS-1:0]  addr_key;
   logic                     buf_a;
   logic [TABLE_ENTRIES-1:0] match_a;
   logic [TABLE_ENTRIES-1:0] match_b;
   logic [TABLE_ENTRIES-1:0] wmask;
   logic [TABLE_ENTRIES-1:0] bufmask;
   logic [TABLE_ENTRIES-1:0] free_vec;
   logic [TABLE_ENTRIES-1:0] free_one;

   logic [IW-1:0]            rd_addr;
   logic [SFT_LINES_W-1:0]   lines_rd;
   logic [COUNT_BITS:0]      pend_rd;
   logic [COUNT_BITS-1:0]    pend_cur;
   logic [COUNT_BITS-1:0]    pend_new;
   logic                     pend_we;
   logic [COUNT_BITS:0]      pend_wd;
   logic                     new_entry;
   logic [IW-1:0]            wr_addr;
   logic [TABLE_ENTRIES-1:0] clear_vec;
   logic                     liu_we;
   logic [SFT_USED_W-1:0]    liu_wd;
   logic [SFT_USED_W-1:0]    liu_sel;
   logic [SFT_USED_W:0]      room_sum;
   logic [2:0]               status;
   logic                     present;
   logic                     ready_r;
   logic [SW-1:0]            liu_wide;
   logic [SW-1:0]            freed_wide;
   logic [SFT_USED_W-1:0]    post_used;
   logic [SFT_USED_W:0]      post_sum;

   assign addr_key = ADDRESS_BITS'(req_ff.tile_address);
   assign buf_a    = (req_ff.mode == MODE_LOOKUP_ANY) ? 1'b0 : req_ff.buffer_sel;

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_a[i] = used_ff[i] && (sbuf_ff[i] == buf_a) && (saddr_ff[i] == addr_key);
         match_b[i] = used_ff[i] && sbuf_ff[i] && (saddr_ff[i] == addr_key);
         bufmask[i] = used_ff[i] && (sbuf_ff[i] == req_ff.buffer_sel);
         wmask[i]   = bufmask[i] && !sin_ff[i];
      end
   end

   // Lowest free slot by isolating the lowest set bit.
   assign free_vec = ~used_ff;
   assign free_one = free_vec & (~free_vec + 1'b1);

   assign rd_addr = cmd.rd_sweep ? cnt_ff : hit_idx_ff;
   assign wr_addr = new_entry ? free_idx_ff : hit_idx_ff;

   sft_ram #(.WIDTH(SFT_LINES_W), .DEPTH(TABLE_ENTRIES)) u_lines_ram (
      .clock   (clock),
      .wr_en   (new_entry),
      .wr_addr (wr_addr),
      .wr_data (req_ff.alloc_lines),
      .rd_addr (rd_addr),
      .rd_data (lines_rd)
   );

   sft_ram #(.WIDTH(COUNT_BITS + 1), .DEPTH(TABLE_ENTRIES)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (wr_addr),
      .wr_data (pend_wd),
      .rd_addr (rd_addr),
      .rd_data (pend_rd)
   );

   assign pend_cur = pend_rd[COUNT_BITS-1:0];
   assign liu_sel  = liu_ff[req_ff.buffer_sel];
   assign room_sum = {1'b0, liu_sel} + (SFT_USED_W + 1)'(req_ff.alloc_lines);
   assign liu_wide   = SW'(liu_sel);
   assign freed_wide = SW'(freed_ff);

   always_comb begin
      status    = ST_OK;
      present   = 1'b0;
      ready_r   = 1'b0;
      new_entry = 1'b0;
      pend_we   = 1'b0;
      pend_new  = pend_cur;
      pend_wd   = pend_rd;
      clear_vec = '0;
      liu_we    = 1'b0;
      liu_wd    = liu_sel;
      case (req_ff.mode)
         MODE_LOOKUP, MODE_LOOKUP_ANY: begin
            present = hit_ff;
            ready_r = hit_ff && pend_rd[COUNT_BITS];
         end
         MODE_RESERVE: begin
            if (hit_ff) begin
               present = 1'b1;
               ready_r = pend_rd[COUNT_BITS];
               if (!acc_mode_ff) begin
                  status = ST_PRESENT;
               end else if (lines_rd != req_ff.alloc_lines) begin
                  status = ST_MISMATCH;
               end
            end else if (room_sum > {1'b0, cap_ff}) begin
               status = ST_NO_ROOM;
            end else if (!free_ok_ff) begin
               status = ST_TABLE_FULL;
            end else begin
               present   = 1'b1;
               new_entry = 1'b1;
               pend_we   = 1'b1;
               pend_wd   = {1'b0, COUNT_BITS'(req_ff.request_count)};
               liu_we    = 1'b1;
               liu_wd    = SFT_USED_W'(room_sum);
            end
         end
         MODE_FILL: begin
            if (!hit_ff) begin
               status = ST_NOT_ALLOC;
            end else begin
               present = 1'b1;
               if (pend_cur == '0 || pend_rd[COUNT_BITS]) begin
                  status  = ST_BAD_FILL;
                  ready_r = pend_rd[COUNT_BITS];
               end else begin
                  pend_new = pend_cur - 1'b1;
                  ready_r  = (pend_new == '0);
                  pend_we  = 1'b1;
                  pend_wd  = {ready_r, pend_new};
               end
            end
         end
         MODE_COUNT_UP: begin
            if (!hit_ff) begin
               status = ST_NOT_ALLOC;
            end else begin
               present  = 1'b1;
               pend_new = (pend_cur == '1) ? pend_cur : pend_cur + 1'b1;
               pend_we  = 1'b1;
               pend_wd  = {1'b0, pend_new};
            end
         end
         MODE_FLUSH: begin
            clear_vec = bufmask;
            liu_we    = 1'b1;
            liu_wd    = '0;
         end
         MODE_FLUSH_W: begin
            clear_vec = wmask_ff;
            liu_we    = 1'b1;
            liu_wd    = (liu_wide >= freed_wide) ? SFT_USED_W'(liu_wide - freed_wide) : '0;
         end
         default: begin
         end
      endcase
      if (!cmd.exec) begin
         new_entry = 1'b0;
         pend_we   = 1'b0;
         liu_we    = 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_match) begin
         hit_ff      <= (|match_a) || ((req_ff.mode == MODE_LOOKUP_ANY) && (|match_b));
         hit_idx_ff  <= (|match_a) ? encode(match_a) : encode(match_b);
         free_ok_ff  <= |free_vec;
         free_idx_ff <= encode(free_one);
         wmask_ff    <= wmask;
      end
      acc_idx_ff <= cnt_ff;
      if (cmd.load_match) begin
         freed_ff <= '0;
      end else if (acc_vld_ff && wmask_ff[acc_idx_ff]) begin
         freed_ff <= freed_ff + FW'(lines_rd);
      end
      if (new_entry) begin
         sbuf_ff[free_idx_ff]  <= req_ff.buffer_sel;
         sin_ff[free_idx_ff]   <= req_ff.holds_input;
         saddr_ff[free_idx_ff] <= addr_key;
      end
      if (cmd.exec) begin
         res_status_ff  <= status;
         res_present_ff <= present;
         res_ready_ff   <= ready_r;
         res_fresh_ff   <= new_entry;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status        <= res_status_ff;
         rsp_ff.present       <= res_present_ff;
         rsp_ff.ready_res     <= res_ready_ff;
         rsp_ff.reserved_new  <= res_fresh_ff;
         rsp_ff.room_for_size <= (post_sum <= {1'b0, cap_ff});
         rsp_ff.not_full      <= (post_used < cap_ff);
         rsp_ff.used_lines    <= post_used;
      end
   end

   assign post_used = liu_sel;
   assign post_sum  = {1'b0, post_used} + (SFT_USED_W + 1)'(req_ff.alloc_lines);

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         liu_ff[0]    <= '0;
         liu_ff[1]    <= '0;
         cap_ff       <= CAPACITY_RESET;
         acc_mode_ff  <= 1'b0;
         cnt_ff       <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff      <= csr_wdata;
               CSR_ACC_MODE: acc_mode_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.exec) begin
            used_ff <= (used_ff & ~clear_vec) |
                       (new_entry ? (TABLE_ENTRIES'(1) << free_idx_ff) : '0);
         end
         if (liu_we) begin
            liu_ff[req_ff.buffer_sel] <= liu_wd;
         end
         if (cmd.load_match) begin
            cnt_ff <= '0;
         end else if (cmd.rd_sweep) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         acc_vld_ff <= cmd.rd_sweep;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.mode       = req_ff.mode;
   assign sts.sweep_last = (cnt_ff == IW'(TABLE_ENTRIES - 1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SFT_ASSERT_IMPLY(a_match_unique, clock, reset, cmd.load_match, $onehot0(match_a))
   `SFT_ASSERT_IMPLY(a_new_slot_free, clock, reset, new_entry, !used_ff[free_idx_ff])
   `SFT_ASSERT_IMPLY(a_write_on_hit, clock, reset, pend_we && !new_entry, hit_ff)

endmodule

FILE: design/scratchpad_fill_tracker.sv
// A request accepted while idle steps through search, table read, execute and response load
// before its response is raised; a weights-only flush sweeps the lines memory and drains in
// place of the table read, summing its freed size over the sweep, one slot per cycle.
// The controller walks each request through these steps and takes no new request until it is
// back in idle; a stalled response adds its stall.
// Reset (synchronous, active high) empties the table, zeroes both used-line counts
// and sets capacity to 4096 lines with accumulate mode off.
module scratchpad_fill_tracker #(
   parameter int TABLE_ENTRIES = 64,
   parameter int ADDRESS_BITS  = 32,
   parameter int COUNT_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sft_pkg::sft_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sft_pkg::sft_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [16:0]          csr_wdata
);
   import sft_pkg::*;

   // The controller sequences each request through the datapath. It accepts a new
   // request as soon as it is idle, even while the previous response still waits in
   // the output register; it only stalls before loading a new response.
   sft_cmd_type cmd;
   sft_sts_type sts;

   sft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the tag flops (matched in parallel), the lines and pending
   // memories, the per-buffer used-line counters and the configuration registers.
   sft_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDRESS_BITS  (ADDRESS_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
